@@ rtl/dtc_pkg.sv @@
// Package for the DAG transitive closure core: widths, sequencer ops, command struct.
`default_nettype none
package dtc_pkg;

    localparam int ARC_W         = 6;
    localparam int REACH_W       = 64;
    localparam int MAX_NODES_DEF = 64;

    // Operation carried by a row read into the datapath's second stage
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_ARC   = 3'd1;
    localparam logic [2:0] OP_PIVOT = 3'd2;
    localparam logic [2:0] OP_CLOSE = 3'd3;
    localparam logic [2:0] OP_EMIT  = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [ARC_W-1:0] addr;
        logic [ARC_W-1:0] pivot;
        logic [ARC_W-1:0] dst;
        logic             last;
        logic             emit_cyc;
        logic             clear;
    } cmd_t;

endpackage
`default_nettype wire

@@ rtl/dag_transitive_closure_core.sv @@
// Top level of the DAG transitive closure core: controller plus datapath.
//
// Arcs enter on start while busy is low: arc_source, arc_target and last_arc
// are taken at that clock edge. Arcs not marked last keep busy low, so a
// graph loads at one arc per cycle.
// The arc marked last raises busy. With N nodes (largest index plus one) a check
// state is followed by N pivots, each pivot reading its own row and then every
// row of the 1R1W matrix RAM once. A flush state lets the last write land and
// the cycle flag settle. A cyclic graph then gives one result (graph_cyclic and
// last_row high, no rows) in its clearing cycle.
// Otherwise rows 0..N-1 follow on consecutive cycles, the last one with
// last_row; the last row shows in the first cycle with busy low.
// Each result is on the ports for one cycle, marked by result_strobe; the
// receiver cannot stall. A graph with no kept arcs gives no result and only
// clears.
// Reset is asynchronous, active low, and leaves an empty graph; row valid
// bits make stale RAM contents read as zero, so no clearing pass is needed.
`default_nettype none
module dag_transitive_closure_core #(
    parameter int MAX_NODES = dtc_pkg::MAX_NODES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [dtc_pkg::ARC_W-1:0]   arc_source,
    input  wire logic [dtc_pkg::ARC_W-1:0]   arc_target,
    input  wire logic                        last_arc,
    output logic                             result_strobe,
    output logic [dtc_pkg::ARC_W-1:0]        row_node,
    output logic [dtc_pkg::REACH_W-1:0]      row_reach,
    output logic                             graph_cyclic,
    output logic                             last_row
);
    import dtc_pkg::*;

    cmd_t cmd;
    logic cyclic;

    dtc_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .arc_source (arc_source),
        .arc_target (arc_target),
        .last_arc   (last_arc),
        .cyclic     (cyclic),
        .busy       (busy),
        .cmd        (cmd)
    );

    dtc_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cyclic        (cyclic),
        .result_strobe (result_strobe),
        .row_node      (row_node),
        .row_reach     (row_reach),
        .graph_cyclic  (graph_cyclic),
        .last_row      (last_row)
    );

endmodule
`default_nettype wire

@@ rtl/dtc_ram.sv @@
// Generic single-write, single-read RAM with registered read (old data on collision).
`default_nettype none
module dtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/dtc_datapath.sv @@
// Datapath: reach matrix RAM, row valid bits, forwarding, closure update and result registers.
`default_nettype none
module dtc_datapath #(
    parameter int MAX_NODES = dtc_pkg::MAX_NODES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dtc_pkg::cmd_t                cmd,
    output logic                              cyclic,
    output logic                              result_strobe,
    output logic [dtc_pkg::ARC_W-1:0]         row_node,
    output logic [dtc_pkg::REACH_W-1:0]       row_reach,
    output logic                              graph_cyclic,
    output logic                              last_row
);
    import dtc_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int ROW_W  = MAX_NODES;

    // second stage: what to do with the row arriving from the RAM
    logic [2:0]        s2_op_reg;
    logic [NODE_W-1:0] s2_addr_reg;
    logic [NODE_W-1:0] s2_pivot_reg;
    logic [NODE_W-1:0] s2_dst_reg;
    logic              s2_last_reg;

    logic [ROW_W-1:0]  row_valid_reg, row_valid_next;
    logic              wr_last_valid_reg;
    logic [NODE_W-1:0] wr_last_addr_reg;
    logic [ROW_W-1:0]  wr_last_data_reg;
    logic [ROW_W-1:0]  pivot_row_reg, pivot_row_next;
    logic              cyc_reg, cyc_next;

    logic              strobe_reg, strobe_next;
    logic [ARC_W-1:0]  node_reg, node_next;
    logic [REACH_W-1:0] reach_reg, reach_next;
    logic              cyc_out_reg, cyc_out_next;
    logic              last_reg, last_next;

    logic              rd_en;
    logic [ROW_W-1:0]  rdata;
    logic [ROW_W-1:0]  row_cur;
    logic              we;
    logic [ROW_W-1:0]  wdata;

    assign rd_en = (cmd.op != OP_NONE);

    dtc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_NODES)
    ) u_matrix (
        .clk   (clk),
        .we    (we),
        .waddr (s2_addr_reg),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (cmd.addr[NODE_W-1:0]),
        .rdata (rdata)
    );

    // a row written last cycle is not yet in the read data
    always_comb
    begin
        if (wr_last_valid_reg && (wr_last_addr_reg == s2_addr_reg))
        begin
            row_cur = wr_last_data_reg;
        end
        else if (row_valid_reg[s2_addr_reg])
        begin
            row_cur = rdata;
        end
        else
        begin
            row_cur = '0;
        end
    end

    always_comb
    begin
        we             = 1'b0;
        wdata          = row_cur;
        pivot_row_next = pivot_row_reg;
        strobe_next    = 1'b0;
        node_next      = node_reg;
        reach_next     = reach_reg;
        cyc_out_next   = cyc_out_reg;
        last_next      = last_reg;
        case (s2_op_reg)
            OP_ARC:
            begin
                we    = 1'b1;
                wdata = row_cur | (ROW_W'(1) << s2_dst_reg);
            end
            OP_PIVOT:
            begin
                pivot_row_next = row_cur;
            end
            OP_CLOSE:
            begin
                we    = row_cur[s2_pivot_reg];
                wdata = row_cur | pivot_row_reg;
            end
            OP_EMIT:
            begin
                strobe_next  = 1'b1;
                node_next    = ARC_W'(s2_addr_reg);
                reach_next   = REACH_W'(row_cur);
                cyc_out_next = 1'b0;
                last_next    = s2_last_reg;
            end
            default:
            begin
            end
        endcase
        if (cmd.emit_cyc)
        begin
            strobe_next  = 1'b1;
            node_next    = '0;
            reach_next   = '0;
            cyc_out_next = 1'b1;
            last_next    = 1'b1;
        end
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        cyc_next       = cyc_reg;
        if (we)
        begin
            row_valid_next[s2_addr_reg] = 1'b1;
            // a node reaching itself marks the graph cyclic; bits never clear
            if (wdata[s2_addr_reg])
            begin
                cyc_next = 1'b1;
            end
        end
        if (cmd.clear)
        begin
            row_valid_next = '0;
            cyc_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_op_reg         <= OP_NONE;
            row_valid_reg     <= '0;
            wr_last_valid_reg <= 1'b0;
            cyc_reg           <= 1'b0;
            strobe_reg        <= 1'b0;
        end
        else
        begin
            s2_op_reg         <= cmd.op;
            row_valid_reg     <= row_valid_next;
            wr_last_valid_reg <= we;
            cyc_reg           <= cyc_next;
            strobe_reg        <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_addr_reg      <= cmd.addr[NODE_W-1:0];
        s2_pivot_reg     <= cmd.pivot[NODE_W-1:0];
        s2_dst_reg       <= cmd.dst[NODE_W-1:0];
        s2_last_reg      <= cmd.last;
        wr_last_addr_reg <= s2_addr_reg;
        wr_last_data_reg <= wdata;
        pivot_row_reg    <= pivot_row_next;
        node_reg         <= node_next;
        reach_reg        <= reach_next;
        cyc_out_reg      <= cyc_out_next;
        last_reg         <= last_next;
    end

    assign cyclic        = cyc_reg;
    assign result_strobe = strobe_reg;
    assign row_node      = node_reg;
    assign row_reach     = reach_reg;
    assign graph_cyclic  = cyc_out_reg;
    assign last_row      = last_reg;

`ifndef NO_ASSERTIONS
    a_emit_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_op_reg == OP_EMIT) |-> !we)
        else $error("matrix written while rows stream out");

    a_cyclic_single: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && cyc_out_reg) |-> (last_reg && (reach_reg == '0)))
        else $error("cyclic result not a lone empty last item");
`endif

endmodule
`default_nettype wire

@@ rtl/dtc_ctrl.sv @@
// Controller: arc intake, closure sequencing over pivots and rows, row emission, clearing.
`default_nettype none
module dtc_ctrl #(
    parameter int MAX_NODES = dtc_pkg::MAX_NODES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [dtc_pkg::ARC_W-1:0] arc_source,
    input  wire logic [dtc_pkg::ARC_W-1:0] arc_target,
    input  wire logic                      last_arc,
    input  wire logic                      cyclic,
    output logic                           busy,
    output dtc_pkg::cmd_t                  cmd
);
    import dtc_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_PIVOT  = 3'd2;
    localparam logic [2:0] ST_CLOSE  = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;
    localparam logic [2:0] ST_CLEAR  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [NODE_W-1:0] k_reg, k_next;
    logic [NODE_W-1:0] i_reg, i_next;

    logic              in_range;
    logic [CNT_W-1:0]  src_cnt;
    logic [CNT_W-1:0]  dst_cnt;
    logic              i_at_end;
    logic              k_at_end;

    assign in_range = ({1'b0, arc_source} < (ARC_W + 1)'(MAX_NODES))
                   && ({1'b0, arc_target} < (ARC_W + 1)'(MAX_NODES));
    assign src_cnt  = CNT_W'(arc_source[NODE_W-1:0]) + CNT_W'(1);
    assign dst_cnt  = CNT_W'(arc_target[NODE_W-1:0]) + CNT_W'(1);
    assign i_at_end = ((CNT_W'(i_reg) + CNT_W'(1)) == n_reg);
    assign k_at_end = ((CNT_W'(k_reg) + CNT_W'(1)) == n_reg);
    assign busy     = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        cmd          = '0;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (in_range)
                    begin
                        cmd.op   = OP_ARC;
                        cmd.addr = arc_source;
                        cmd.dst  = arc_target;
                        if (src_cnt > n_next)
                        begin
                            n_next = src_cnt;
                        end
                        if (dst_cnt > n_next)
                        begin
                            n_next = dst_cnt;
                        end
                    end
                    if (last_arc)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (n_reg == '0)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_PIVOT;
                end
            end
            ST_PIVOT:
            begin
                cmd.op     = OP_PIVOT;
                cmd.addr   = ARC_W'(k_reg);
                i_next     = '0;
                state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                cmd.op    = OP_CLOSE;
                cmd.addr  = ARC_W'(i_reg);
                cmd.pivot = ARC_W'(k_reg);
                if (i_at_end)
                begin
                    i_next = '0;
                    if (k_at_end)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        k_next     = k_reg + NODE_W'(1);
                        state_next = ST_PIVOT;
                    end
                end
                else
                begin
                    i_next = i_reg + NODE_W'(1);
                end
            end
            ST_FLUSH:
            begin
                // last closure write lands; cyclic flag settles
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                i_next = '0;
                if (cyclic)
                begin
                    cmd.emit_cyc = 1'b1;
                    state_next   = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.op   = OP_EMIT;
                cmd.addr = ARC_W'(i_reg);
                cmd.last = i_at_end;
                if (i_at_end)
                begin
                    i_next     = '0;
                    state_next = ST_CLEAR;
                end
                else
                begin
                    i_next = i_reg + NODE_W'(1);
                end
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                n_next     = '0;
                k_next     = '0;
                i_next     = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> ((state_reg == ST_IDLE) && (n_reg == '0)))
        else $error("clear did not return to idle with empty graph");

    a_row_in_graph: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_CLOSE) || (cmd.op == OP_EMIT)) |-> (CNT_W'(i_reg) < n_reg))
        else $error("row index beyond node count");
`endif

endmodule
`default_nettype wire
